/* rtl/core/prefix_varint_coeff_decoder_unit_macros.svh */
// assertion macros for the decoder rtl, used by pvcd_ctrl
// no dependencies; expects clk and arst_n in the using module
`ifndef PREFIX_VARINT_COEFF_DECODER_UNIT_MACROS_SVH
`define PREFIX_VARINT_COEFF_DECODER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define PVCD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define PVCD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/pvcd_pkg.sv */
// shared types and constants for the prefix varint coefficient decoder
// no dependencies
package pvcd_pkg;

	localparam int unsigned HdrLen   = 5;
	localparam int unsigned DivSteps = 24;
	localparam int unsigned CntW     = $clog2(DivSteps);

	localparam logic [7:0] HdrVersion = 8'h01;
	localparam logic [7:0] HdrFlag    = 8'h03;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_ROWS    = 2'd0,
		REG_COLS    = 2'd1,
		REG_MODULUS = 2'd2
	} pvcd_reg_t;

	// frame status codes
	typedef enum logic [2:0] {
		STS_OK     = 3'd0,
		STS_SHORT  = 3'd1,
		STS_FORMAT = 3'd2,
		STS_DIM    = 3'd3,
		STS_TRUNC  = 3'd4,
		STS_CODE   = 3'd5
	} pvcd_status_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CALC = 3'b010,
		ST_PUSH = 3'b100
	} pvcd_state_t;

	// controller to datapath
	typedef struct packed {
		logic take;     // input transaction this cycle
		logic div_step; // one remainder iteration
		logic out_load; // move held result into output register
	} pvcd_cmd_t;

	// datapath to controller, valid with take
	typedef struct packed {
		logic res_needed; // this byte produces a result
		logic res_div;    // the result needs a reduction
	} pvcd_sts_t;

endpackage

/* rtl/core/pvcd_ctrl.sv */
// controller state machine: input acceptance, remainder sequencing, output register
// depends on pvcd_pkg and the macros header
`include "prefix_varint_coeff_decoder_unit_macros.svh"

module pvcd_ctrl
	import pvcd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  pvcd_sts_t sts,
	output pvcd_cmd_t cmd
);

	pvcd_state_t       state_q;
	logic [CntW-1:0]   cnt_q;
	logic              out_valid_q;
	logic              out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	assign cmd.take     = in_valid && in_ready;
	assign cmd.div_step = (state_q == ST_CALC);
	assign cmd.out_load = (state_q == ST_PUSH) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (cmd.take && sts.res_needed) begin
						state_q <= sts.res_div ? ST_CALC : ST_PUSH;
					end
				end
				ST_CALC: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CntW'(DivSteps - 1)) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`PVCD_ASSERT_NEXT(a_div_starts, cmd.take && sts.res_needed && sts.res_div,
		state_q == ST_CALC && cnt_q == '0, "reduction did not start after take")
	`PVCD_ASSERT_NOW(a_cnt_range, state_q == ST_CALC, cnt_q < CntW'(DivSteps),
		"remainder step count out of range")
	`PVCD_ASSERT_NEXT(a_load_valid, cmd.out_load, out_valid_q,
		"output register not valid after load")
	`PVCD_ASSERT_NEXT(a_push_free, state_q == ST_PUSH && !out_valid_q, state_q == ST_IDLE,
		"result stuck with free output register")

endmodule

/* rtl/core/pvcd_datapath.sv */
// datapath: config registers, header and prefix-code parsing, remainder unit, result registers
// depends on pvcd_pkg
module pvcd_datapath
	import pvcd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [24:0] cfg_wdata,
	input  logic [7:0]  data_byte,
	input  logic        frame_end,
	input  pvcd_cmd_t   cmd,
	output pvcd_sts_t   sts,
	output logic [23:0] coeff_value,
	output logic [7:0]  row_index,
	output logic [15:0] col_index,
	output logic        coeff_valid,
	output logic        frame_done,
	output logic [2:0]  status
);

	// configuration
	logic [7:0]  rows_q;
	logic [15:0] cols_q;
	logic [24:0] mod_q;

	// frame state
	logic [2:0]  hdr_pos_q;
	logic [7:0]  col_hi_q;
	logic [1:0]  pend_q;
	logic [23:0] acc_q;
	logic [7:0]  row_q;
	logic [15:0] col_q;
	logic        err_q;
	logic [2:0]  err_code_q;
	logic        body_done_q;

	logic [2:0]  n_pos;
	logic [7:0]  n_col_hi;
	logic [1:0]  n_pend;
	logic [23:0] n_acc;
	logic [7:0]  n_row;
	logic [15:0] n_col;
	logic        n_err;
	logic [2:0]  n_code;
	logic        n_body;
	logic        emit;
	logic        done;
	logic [23:0] val;
	logic [7:0]  ri;
	logic [15:0] ci;
	logic [2:0]  st;

	// held result and remainder unit
	logic [23:0] res_val_q;
	logic [7:0]  res_row_q;
	logic [15:0] res_col_q;
	logic        res_emit_q;
	logic        res_fend_q;
	logic [2:0]  res_sts_q;
	logic        res_div_q;
	logic [24:0] rem_q;
	logic [25:0] rem_sh;
	logic [25:0] rem_sub;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 8'd1;
			cols_q <= 16'd256;
			mod_q  <= 25'd3329;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ROWS:    rows_q <= cfg_wdata[7:0];
				REG_COLS:    cols_q <= cfg_wdata[15:0];
				REG_MODULUS: mod_q  <= cfg_wdata;
				default:     ;
			endcase
		end
	end

	always_comb begin
		n_pos    = hdr_pos_q;
		n_col_hi = col_hi_q;
		n_pend   = pend_q;
		n_acc    = acc_q;
		n_row    = row_q;
		n_col    = col_q;
		n_err    = err_q;
		n_code   = err_code_q;
		n_body   = body_done_q;
		emit     = 1'b0;
		done     = 1'b0;
		val      = '0;
		ri       = '0;
		ci       = '0;
		st       = STS_OK;

		if (hdr_pos_q < 3'(HdrLen)) begin
			case (hdr_pos_q)
				3'd0: begin
					if (data_byte != HdrVersion && !n_err) begin
						n_err  = 1'b1;
						n_code = STS_FORMAT;
					end
				end
				3'd1: begin
					if (data_byte != HdrFlag && !n_err) begin
						n_err  = 1'b1;
						n_code = STS_FORMAT;
					end
				end
				3'd2: begin
					if (data_byte != rows_q && !n_err) begin
						n_err  = 1'b1;
						n_code = STS_DIM;
					end
				end
				3'd3: begin
					n_col_hi = data_byte;
				end
				default: begin
					if ({col_hi_q, data_byte} != cols_q && !n_err) begin
						n_err  = 1'b1;
						n_code = STS_DIM;
					end
					if (!n_err && (rows_q == '0 || cols_q == '0)) begin
						n_body = 1'b1;
					end
				end
			endcase
			n_pos = hdr_pos_q + 3'd1;
		end else if (!err_q && !body_done_q) begin
			if (pend_q != 2'd0) begin
				n_acc  = {acc_q[15:0], data_byte};
				n_pend = pend_q - 2'd1;
				done   = (n_pend == 2'd0);
			end else if (data_byte == 8'h00) begin
				n_acc = '0;
				done  = 1'b1;
			end else if ((data_byte & 8'hC0) == 8'h80) begin
				n_acc = {18'd0, data_byte[5:0]};
				done  = 1'b1;
			end else if ((data_byte & 8'hE0) == 8'hC0) begin
				n_acc  = {19'd0, data_byte[4:0]};
				n_pend = 2'd1;
			end else if ((data_byte & 8'hF0) == 8'hE0) begin
				n_acc  = {20'd0, data_byte[3:0]};
				n_pend = 2'd2;
			end else if (data_byte == 8'hF0) begin
				n_acc  = '0;
				n_pend = 2'd3;
			end else begin
				n_err  = 1'b1;
				n_code = STS_CODE;
			end
			if (done) begin
				val  = n_acc;
				ri   = row_q;
				ci   = col_q;
				emit = 1'b1;
				if ({1'b0, col_q} + 17'd1 >= {1'b0, cols_q}) begin
					n_col = '0;
					if ({1'b0, row_q} + 9'd1 >= {1'b0, rows_q}) begin
						n_body = 1'b1;
					end
					n_row = row_q + 8'd1;
				end else begin
					n_col = col_q + 16'd1;
				end
				n_acc = '0;
			end
		end

		if (frame_end) begin
			if (n_pos < 3'(HdrLen)) begin
				st = STS_SHORT;
			end else if (n_err) begin
				st = n_code;
			end else if (!n_body) begin
				st = STS_TRUNC;
			end
			n_pos    = '0;
			n_col_hi = '0;
			n_pend   = '0;
			n_acc    = '0;
			n_row    = '0;
			n_col    = '0;
			n_err    = 1'b0;
			n_code   = STS_OK;
			n_body   = 1'b0;
		end
	end

	assign sts.res_needed = emit || frame_end;
	assign sts.res_div    = emit && (mod_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos_q   <= '0;
			col_hi_q    <= '0;
			pend_q      <= '0;
			acc_q       <= '0;
			row_q       <= '0;
			col_q       <= '0;
			err_q       <= 1'b0;
			err_code_q  <= STS_OK;
			body_done_q <= 1'b0;
		end else if (cmd.take) begin
			hdr_pos_q   <= n_pos;
			col_hi_q    <= n_col_hi;
			pend_q      <= n_pend;
			acc_q       <= n_acc;
			row_q       <= n_row;
			col_q       <= n_col;
			err_q       <= n_err;
			err_code_q  <= n_code;
			body_done_q <= n_body;
		end
	end

	// restoring remainder, one dividend bit per step, msb first
	assign rem_sh  = {rem_q, res_val_q[23]};
	assign rem_sub = rem_sh - {1'b0, mod_q};

	always_ff @(posedge clk) begin
		if (cmd.take && sts.res_needed) begin
			res_val_q  <= val;
			res_row_q  <= ri;
			res_col_q  <= ci;
			res_emit_q <= emit;
			res_fend_q <= frame_end;
			res_sts_q  <= st;
			res_div_q  <= sts.res_div;
			rem_q      <= '0;
		end else if (cmd.div_step) begin
			res_val_q <= {res_val_q[22:0], 1'b0};
			rem_q     <= (rem_sh >= {1'b0, mod_q}) ? rem_sub[24:0] : rem_sh[24:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			coeff_value <= res_div_q ? rem_q[23:0] : res_val_q;
			row_index   <= res_row_q;
			col_index   <= res_col_q;
			coeff_valid <= res_emit_q;
			frame_done  <= res_fend_q;
			status      <= res_sts_q;
		end
	end

endmodule

/* rtl/core/prefix_varint_coeff_decoder_unit.sv */
// top level of the prefix varint coefficient decoder
// depends on pvcd_pkg, pvcd_ctrl and pvcd_datapath
//
// channel   direction  tdata                         tuser / tlast
// s_axis    in         [7:0] data_byte               tlast = frame_end
// m_axis    out        [23:0] coeff_value,           tuser[0] coeff_valid,
//                      [31:24] row_index,            tuser[3:1] status,
//                      [47:32] col_index             tlast = frame_done
// cfg       in         cfg_addr 0 rows, 1 cols, 2 modulus (cfg_wdata, no read-back)
//
// a byte that completes no coefficient and no frame, such as a header byte, leaves the input ready
// a byte that only closes a frame goes to the held result, then to the output register when it frees
// a completed coefficient is accepted, runs 24 steps of the bit-serial
//   remainder unit against the runtime modulus, then is loaded into the output register
// a zero modulus skips the remainder unit (identity)
// reset is asynchronous, active low; all frame state and the output valid clear,
//   configuration returns to rows 1, cols 256, modulus 3329
// the output register holds one result; while it is stalled the next byte is still
//   taken and its result is held until the register frees
module prefix_varint_coeff_decoder_unit
	import pvcd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [24:0] cfg_wdata,
	// byte stream in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tlast,  // frame_end
	// coefficient stream out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // [23:0] coeff_value, [31:24] row_index, [47:32] col_index
	output logic [3:0]  m_axis_tuser,  // [0] coeff_valid, [3:1] status
	output logic        m_axis_tlast   // frame_done
);

	pvcd_cmd_t cmd;
	pvcd_sts_t sts;

	// controller: handshakes and the remainder step count
	pvcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: parsing, remainder unit and the output payload register
	pvcd_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.data_byte   (s_axis_tdata),
		.frame_end   (s_axis_tlast),
		.cmd         (cmd),
		.sts         (sts),
		.coeff_value (m_axis_tdata[23:0]),
		.row_index   (m_axis_tdata[31:24]),
		.col_index   (m_axis_tdata[47:32]),
		.coeff_valid (m_axis_tuser[0]),
		.frame_done  (m_axis_tlast),
		.status      (m_axis_tuser[3:1])
	);

endmodule
